### rtl/core/ufe_pkg.sv
package ufe_pkg;

  localparam int IDX_W            = 10;
  localparam int CNT_W            = 11;
  localparam int SIZE_W           = 11;
  localparam int MODE_W           = 2;
  localparam int IN_DATA_W        = 24;
  localparam int OUT_DATA_W       = 40;
  localparam int DEF_MAX_ELEMENTS = 1024;

  localparam logic [MODE_W-1:0] MODE_FIND  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MERGE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CONN  = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0] first_root;
    logic [IDX_W-1:0] second_root;
    logic             same_set;
    logic             did_merge;
    logic [CNT_W-1:0] set_total;
    logic             index_error;
  } result_t;

endpackage

### rtl/core/union_find_engine_core.sv
// Find: walk parent links up to the root, then point each node on the path at that root.
// Connected: a second walk for the second index; merge links the smaller root under the other.
// Every cycle is one access of the single-port forest RAM; one item at a time.
// Out-of-range items: result with index_error set and no forest walk.
// Reset (synchronous) and every element_count write start a clearing pass over
// all MAX_ELEMENTS RAM words, during which s_axis_tready is low.
module union_find_engine_core #(
  parameter int MAX_ELEMENTS = ufe_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ufe_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // first_index, second_index
  input  logic [ufe_pkg::MODE_W-1:0]     s_axis_tuser,  // mode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ufe_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // first_root, second_root,
                                                        // same_set, did_merge, set_total
  output logic [0:0]                     m_axis_tuser,  // index_error
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ufe_pkg::CNT_W-1:0]      cfg_data       // element_count
);

  import ufe_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int WORD_W = SIZE_W + AW;
  localparam logic [CNT_W-1:0] RESET_COUNT =
    CNT_W'((MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024);

  logic [CNT_W-1:0] element_count;
  logic [CNT_W-1:0] cfg_sat;
  logic             clear_req;

  logic             res_valid;
  logic             res_take;
  result_t          res;

  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_sat = cfg_data;
    if (cfg_data == '0) begin
      cfg_sat = CNT_W'(1);
    end else if (32'(cfg_data) > MAX_ELEMENTS) begin
      cfg_sat = CNT_W'(MAX_ELEMENTS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= RESET_COUNT;
      clear_req     <= 1'b0;
    end else begin
      clear_req <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) element_count <= cfg_sat;
    end
  end

  ufe_seq #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_seq (
    .clk           (clk),
    .rst           (rst),
    .clear_req     (clear_req),
    .element_count (element_count),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_mode       (s_axis_tuser),
    .in_first      (s_axis_tdata[IDX_W-1:0]),
    .in_second     (s_axis_tdata[2*IDX_W-1:IDX_W]),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res),
    .mem_addr      (mem_addr),
    .mem_we        (mem_we),
    .mem_wdata     (mem_wdata),
    .mem_rdata     (mem_rdata)
  );

  ufe_forest_ram #(.DEPTH(MAX_ELEMENTS), .WIDTH(WORD_W)) u_ram (
    .clk   (clk),
    .addr  (mem_addr),
    .we    (mem_we),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign res_take = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= res_valid;
    end
    if (res_take && res_valid) begin
      m_axis_tdata <= {7'd0, res.set_total, res.did_merge, res.same_set,
                       res.second_root, res.first_root};
      m_axis_tuser <= res.index_error;
    end
  end

endmodule

### rtl/core/ufe_forest_ram.sv
module ufe_forest_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 21
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/core/ufe_seq.sv
module ufe_seq #(
  parameter int MAX_ELEMENTS = ufe_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          clear_req,
  input  logic [ufe_pkg::CNT_W-1:0]                     element_count,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [ufe_pkg::MODE_W-1:0]                    in_mode,
  input  logic [ufe_pkg::IDX_W-1:0]                     in_first,
  input  logic [ufe_pkg::IDX_W-1:0]                     in_second,
  output logic                                          res_valid,
  input  logic                                          res_take,
  output ufe_pkg::result_t                              res,
  output logic [$clog2(MAX_ELEMENTS)-1:0]               mem_addr,
  output logic                                          mem_we,
  output logic [ufe_pkg::SIZE_W+$clog2(MAX_ELEMENTS)-1:0] mem_wdata,
  input  logic [ufe_pkg::SIZE_W+$clog2(MAX_ELEMENTS)-1:0] mem_rdata
);

  import ufe_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ELEMENTS - 1);

  typedef enum logic [2:0] {
    CLEAR, IDLE, UP, CMP_RD, CMP_WR, START_B, MRG_A, MRG_B
  } state_t;

  state_t state;
  logic             done;
  logic [AW-1:0]    clr_addr;
  logic [AW-1:0]    top;
  logic [AW-1:0]    walk;
  logic [AW-1:0]    b_addr;
  logic [AW-1:0]    ra;
  logic [AW-1:0]    rb;
  logic [SIZE_W-1:0] size_a;
  logic [SIZE_W-1:0] size_b;
  logic [MODE_W-1:0] mode_r;
  logic             phase;
  logic             same;
  logic             merged;
  logic             err;
  logic [CNT_W-1:0] set_count;

  logic [AW-1:0]     rd_link;
  logic [SIZE_W-1:0] rd_size;
  logic [SIZE_W-1:0] size_sum;
  logic              a_small;
  logic              bad;
  logic              fin;

  assign rd_link  = mem_rdata[AW-1:0];
  assign rd_size  = mem_rdata[SIZE_W+AW-1:AW];
  assign size_sum = SIZE_W'(size_a + size_b);
  assign a_small  = size_a < size_b;
  assign bad      = ({1'b0, in_first} >= element_count) ||
                    ((in_mode != MODE_FIND) && ({1'b0, in_second} >= element_count));
  assign fin      = ((state == UP) && (rd_link == top) && (walk == top)) ||
                    ((state == CMP_WR) && (rd_link == top));

  assign in_ready  = (state == IDLE) && !done && !clear_req;
  assign res_valid = done;

  always_comb begin
    res.first_root  = IDX_W'(ra);
    res.second_root = IDX_W'(rb);
    res.same_set    = same;
    res.did_merge   = merged;
    res.set_total   = set_count;
    res.index_error = err;
  end

  always_comb begin
    mem_addr  = '0;
    mem_we    = 1'b0;
    mem_wdata = '0;
    unique case (state)
      CLEAR: begin
        mem_addr  = clr_addr;
        mem_we    = 1'b1;
        mem_wdata = {SIZE_W'(1), clr_addr};
      end
      IDLE:    mem_addr = AW'(in_first);
      UP:      mem_addr = rd_link;
      CMP_RD:  mem_addr = walk;
      CMP_WR: begin
        mem_addr  = walk;
        mem_we    = 1'b1;
        mem_wdata = {rd_size, top};
      end
      START_B: mem_addr = top;
      MRG_A: begin
        mem_we = 1'b1;
        if (a_small) begin
          mem_addr  = ra;
          mem_wdata = {size_a, rb};
        end else begin
          mem_addr  = rb;
          mem_wdata = {size_b, ra};
        end
      end
      MRG_B: begin
        mem_we = 1'b1;
        if (a_small) begin
          mem_addr  = rb;
          mem_wdata = {size_sum, rb};
        end else begin
          mem_addr  = ra;
          mem_wdata = {size_sum, ra};
        end
      end
      default: mem_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else if (clear_req) begin
      state    <= CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      unique case (state)
        CLEAR: begin
          if (clr_addr == LAST_ADDR) begin
            state     <= IDLE;
            set_count <= element_count;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        IDLE: begin
          if (done) begin
            if (res_take) done <= 1'b0;
          end else if (in_valid) begin
            mode_r <= in_mode;
            top    <= AW'(in_first);
            walk   <= AW'(in_first);
            b_addr <= AW'(in_second);
            phase  <= 1'b0;
            ra     <= '0;
            rb     <= '0;
            same   <= 1'b0;
            merged <= 1'b0;
            err    <= bad;
            if (bad) begin
              done <= 1'b1;
            end else begin
              state <= UP;
            end
          end
        end
        UP: begin
          if (rd_link == top) begin
            if (!phase) size_a <= rd_size;
            else        size_b <= rd_size;
            if (walk != top) state <= CMP_RD;
          end else begin
            top <= rd_link;
          end
        end
        CMP_RD: state <= CMP_WR;
        CMP_WR: begin
          if (rd_link != top) begin
            walk  <= rd_link;
            state <= CMP_RD;
          end
        end
        START_B: state <= UP;
        MRG_A:   state <= MRG_B;
        MRG_B: begin
          if (a_small) ra <= rb;
          else         rb <= ra;
          merged <= 1'b1;
          if (set_count != '0) set_count <= set_count - 1'b1;
          state <= IDLE;
          done  <= 1'b1;
        end
        default: state <= IDLE;
      endcase

      if (fin) begin
        if (!phase) begin
          ra <= top;
          if (mode_r == MODE_FIND) begin
            state <= IDLE;
            done  <= 1'b1;
          end else begin
            phase <= 1'b1;
            top   <= b_addr;
            walk  <= b_addr;
            state <= START_B;
          end
        end else begin
          rb   <= top;
          same <= (ra == top);
          if ((mode_r == MODE_MERGE) && (ra != top)) begin
            state <= MRG_A;
          end else begin
            state <= IDLE;
            done  <= 1'b1;
          end
        end
      end
    end
  end

endmodule

### rtl/core/ufe_checker.sv
module ufe_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [ufe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic [ufe_pkg::MODE_W-1:0]     s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ufe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]                     m_axis_tuser,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [ufe_pkg::CNT_W-1:0]      cfg_data
);

  import ufe_pkg::*;

  // error results carry no roots and no merge
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[2*IDX_W+1:0] == '0))
    else $error("error item carries roots or flags");

  // a merge reports one common root and distinct sets before
  a_merge_root: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[2*IDX_W+1]) |->
      ((m_axis_tdata[IDX_W-1:0] == m_axis_tdata[2*IDX_W-1:IDX_W]) &&
       !m_axis_tdata[2*IDX_W] && !m_axis_tuser[0]))
    else $error("merge item inconsistent");

  // clearing pass follows reset and each element_count write
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input accepted right after reset");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> !s_axis_tready)
    else $error("input accepted right after element_count write");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output item changed");

endmodule

bind union_find_engine_core ufe_checker u_ufe_checker (.*);
